/* hdl/qvc_pkg.sv */
// Shared types and constants of the QUIC variable-length integer codec.
package qvc_pkg;

  // Command carried by an input item.
  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } qvc_cmd_e;

  // Kind of a result item.
  typedef enum logic {
    KIND_ENC = 1'b0,
    KIND_DEC = 1'b1
  } qvc_kind_e;

  // Result status.
  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_TOO_BIG = 1'b1
  } qvc_status_e;

  // Largest value that fits each encoded length.
  localparam logic [63:0] MAX_LEN1 = 64'd63;
  localparam logic [63:0] MAX_LEN2 = 64'd16383;
  localparam logic [63:0] MAX_LEN4 = 64'd1073741823;
  localparam logic [63:0] MAX_LEN8 = 64'd4611686018427387903;

  // Length prefixes placed in the top two bits of the first byte.
  localparam logic [7:0] PREFIX_LEN1 = 8'h00;
  localparam logic [7:0] PREFIX_LEN2 = 8'h40;
  localparam logic [7:0] PREFIX_LEN4 = 8'h80;
  localparam logic [7:0] PREFIX_LEN8 = 8'hc0;
  localparam logic [7:0] PAYLOAD_MASK = 8'h3f;

  // Work item handed from the front to the back through the queue.
  typedef struct packed {
    qvc_kind_e   kind;
    qvc_status_e status;
    logic [3:0]  len;
    logic [61:0] value;
  } qvc_entry_t;

endpackage

/* hdl/qvc_front.sv */
// Front end: accepts items, sizes encode values and runs the byte-wise decoder.
module qvc_front
  import qvc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  qvc_cmd_e    cmd_i,
  input  logic [63:0] enc_value_i,
  input  logic [7:0]  in_byte_i,
  output logic        wr_en_o,
  output qvc_entry_t  wr_entry_o
);

  logic [2:0]  bytes_left_q, bytes_left_d;
  logic [61:0] acc_q, acc_d;
  logic [3:0]  dec_len_q, dec_len_d;

  // Decoder state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
      acc_q        <= '0;
      dec_len_q    <= '0;
    end else begin
      bytes_left_q <= bytes_left_d;
      acc_q        <= acc_d;
      dec_len_q    <= dec_len_d;
    end
  end

  // Classify the item and build the queue entry it produces, if any.
  always_comb begin
    bytes_left_d = bytes_left_q;
    acc_d        = acc_q;
    dec_len_d    = dec_len_q;
    wr_en_o      = 1'b0;
    wr_entry_o   = '{kind: KIND_ENC, status: STATUS_OK, len: 4'd0, value: '0};
    if (accept_i) begin
      unique case (cmd_i)
        CMD_ENCODE: begin
          // Every encode transfer yields one entry; the back splits it into bytes.
          wr_en_o          = 1'b1;
          wr_entry_o.value = enc_value_i[61:0];
          priority if (enc_value_i <= MAX_LEN1) begin
            wr_entry_o.len = 4'd1;
          end else if (enc_value_i <= MAX_LEN2) begin
            wr_entry_o.len = 4'd2;
          end else if (enc_value_i <= MAX_LEN4) begin
            wr_entry_o.len = 4'd4;
          end else if (enc_value_i <= MAX_LEN8) begin
            wr_entry_o.len = 4'd8;
          end else begin
            wr_entry_o.status = STATUS_TOO_BIG;
            wr_entry_o.value  = '0;
          end
        end
        CMD_DECODE: begin
          wr_entry_o.kind = KIND_DEC;
          if (bytes_left_q == 3'd0) begin
            // First byte: the prefix sets the length, the low bits start the value.
            acc_d     = {56'd0, in_byte_i[5:0]};
            dec_len_d = 4'd1 << in_byte_i[7:6];
            if (in_byte_i[7:6] == 2'b00) begin
              wr_en_o          = 1'b1;
              wr_entry_o.len   = 4'd1;
              wr_entry_o.value = {56'd0, in_byte_i[5:0]};
            end else begin
              bytes_left_d = 3'(dec_len_d - 4'd1);
            end
          end else begin
            // Continuation byte: shift it in, finish when the count runs out.
            acc_d        = {acc_q[53:0], in_byte_i};
            bytes_left_d = bytes_left_q - 3'd1;
            if (bytes_left_q == 3'd1) begin
              wr_en_o          = 1'b1;
              wr_entry_o.len   = dec_len_q;
              wr_entry_o.value = acc_d;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* hdl/qvc_fifo.sv */
// Short first-word-fall-through queue between the front and the back.
module qvc_fifo
  import qvc_pkg::*;
#(
  parameter int Depth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  qvc_entry_t wr_entry_i,
  input  logic       rd_en_i,
  output qvc_entry_t rd_entry_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  qvc_entry_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]       count_q;
  logic                  do_wr, do_rd;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_wr   = wr_en_i && !full_o;
  assign do_rd   = rd_en_i && !empty_o;

  assign rd_entry_o = mem_q[rd_ptr_q];

  // Storage array; entries carry no reset.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* hdl/qvc_back.sv */
// Back end: turns queue entries into result transfers through an output register.
module qvc_back
  import qvc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  qvc_entry_t  head_i,
  output logic        head_pop_o,
  input  logic        pop_i,
  output logic        empty_o,
  output qvc_kind_e   kind_o,
  output logic [7:0]  out_byte_o,
  output logic [61:0] dec_value_o,
  output logic [3:0]  enc_length_o,
  output qvc_status_e status_o,
  output logic        last_o
);

  logic        out_valid_q, out_valid_d;
  logic [2:0]  idx_q, idx_d;
  logic        advance, load;
  logic [2:0]  sel;
  logic [63:0] value64;
  logic [7:0]  byte_n, prefix;
  logic        byte_last;

  qvc_kind_e   kind_q;
  logic [7:0]  byte_q, byte_d;
  logic [61:0] val_q, val_d;
  logic [3:0]  len_q;
  qvc_status_e status_q;
  logic        last_q, last_d;

  assign advance = !out_valid_q || pop_i;
  assign load    = advance && head_valid_i;

  // Pick the byte of the current encode entry, most significant first.
  always_comb begin
    sel       = 3'(head_i.len - 4'd1) - idx_q;
    value64   = {2'b00, head_i.value};
    byte_n    = value64[{sel, 3'b000} +: 8];
    byte_last = (idx_q == 3'(head_i.len - 4'd1));
    unique case (head_i.len)
      4'd2:    prefix = PREFIX_LEN2;
      4'd4:    prefix = PREFIX_LEN4;
      4'd8:    prefix = PREFIX_LEN8;
      default: prefix = PREFIX_LEN1;
    endcase
    if (idx_q == 3'd0) begin
      byte_n = (byte_n & ((head_i.len == 4'd1) ? PAYLOAD_MASK : 8'hff)) | prefix;
    end
  end

  // Result fields and queue pop for the entry at the head.
  always_comb begin
    byte_d     = 8'd0;
    val_d      = '0;
    last_d     = 1'b1;
    head_pop_o = 1'b0;
    idx_d      = idx_q;
    if (head_i.kind == KIND_DEC) begin
      val_d      = head_i.value;
      head_pop_o = load;
    end else if (head_i.status == STATUS_TOO_BIG) begin
      head_pop_o = load;
    end else begin
      byte_d     = byte_n;
      last_d     = byte_last;
      head_pop_o = load && byte_last;
      if (load) begin
        idx_d = byte_last ? 3'd0 : idx_q + 3'd1;
      end
    end
    out_valid_d = advance ? head_valid_i : out_valid_q;
  end

  // Control registers of the output stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  // Payload of the output stage.
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= head_i.kind;
      byte_q   <= byte_d;
      val_q    <= val_d;
      len_q    <= head_i.len;
      status_q <= head_i.status;
      last_q   <= last_d;
    end
  end

  assign empty_o      = !out_valid_q;
  assign kind_o       = kind_q;
  assign out_byte_o   = byte_q;
  assign dec_value_o  = val_q;
  assign enc_length_o = len_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

endmodule

/* hdl/quic_varint_codec_core.sv */
// Top level of the QUIC variable-length integer codec.
//
// An item is accepted on every cycle in which push is high and full is low.
// Decode items take one byte per cycle with no stall of their own; the result
// of an integer enters the queue in the cycle of its final byte. An encode
// item also enters the queue in the cycle it is accepted, but its 1, 2, 4 or 8
// bytes leave the result side one per cycle while results are popped, so a stream
// of encodes is limited by the output serializer, which sends every byte of an
// entry before it pops the next, and full rises once the queue of QueueDepth
// entries between front and back has filled. The first result of an item
// passes through the queue and then loads the output register before it
// reaches the result ports; the output register loads only while it is
// empty or popped. An oversized value gives one error result with status set.
module quic_varint_codec_core
  import qvc_pkg::*;
#(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        cmd_i,
  input  logic [63:0] enc_value_i,
  input  logic [7:0]  in_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [7:0]  out_byte_o,
  output logic [61:0] dec_value_o,
  output logic [3:0]  enc_length_o,
  output logic        status_o,
  output logic        last_o
);

  logic        accept;
  logic        wr_en, rd_en, q_empty;
  qvc_entry_t  wr_entry, head;
  qvc_kind_e   kind;
  qvc_status_e status;

  assign accept = push && !full;

  // Front: item acceptance, length classification and decoder state.
  qvc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .cmd_i      (qvc_cmd_e'(cmd_i)),
    .enc_value_i(enc_value_i),
    .in_byte_i  (in_byte_i),
    .wr_en_o    (wr_en),
    .wr_entry_o (wr_entry)
  );

  // Queue decoupling the front from the back.
  qvc_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_entry_i(wr_entry),
    .rd_en_i   (rd_en),
    .rd_entry_o(head),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  // Back: byte serializer and output register.
  qvc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(!q_empty),
    .head_i      (head),
    .head_pop_o  (rd_en),
    .pop_i       (pop),
    .empty_o     (empty),
    .kind_o      (kind),
    .out_byte_o  (out_byte_o),
    .dec_value_o (dec_value_o),
    .enc_length_o(enc_length_o),
    .status_o    (status),
    .last_o      (last_o)
  );

  assign kind_o   = logic'(kind);
  assign status_o = logic'(status);

endmodule

/* hdl/qvc_checker.sv */
// Port-level checker for the codec core, bound to the top level.
module qvc_checker
  import qvc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic        kind_o,
  input logic [7:0]  out_byte_o,
  input logic [61:0] dec_value_o,
  input logic [3:0]  enc_length_o,
  input logic        status_o,
  input logic        last_o
);

  // A waiting result holds still until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(dec_value_o)
                          && $stable(last_o) && $stable(kind_o)))
    else $error("result changed while stalled");

  // Decoded values are always single, successful transfers.
  a_dec_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_DEC) |-> (last_o && status_o == STATUS_OK))
    else $error("decode result not single or flagged as error");

  // An error result is a lone encode transfer with no length.
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == STATUS_TOO_BIG) |->
      (kind_o == KIND_ENC && enc_length_o == 4'd0 && last_o && out_byte_o == 8'd0))
    else $error("malformed error result");

  // An encode run is not interrupted: the next byte follows at once.
  a_enc_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && kind_o == KIND_ENC && !last_o) |=> (!empty && kind_o == KIND_ENC))
    else $error("encode run broken");

  // Good encode bytes carry a legal length.
  a_enc_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_ENC && status_o == STATUS_OK) |->
      (enc_length_o == 4'd1 || enc_length_o == 4'd2 ||
       enc_length_o == 4'd4 || enc_length_o == 4'd8))
    else $error("illegal encode length");

endmodule

bind quic_varint_codec_core qvc_checker u_qvc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .kind_o      (kind_o),
  .out_byte_o  (out_byte_o),
  .dec_value_o (dec_value_o),
  .enc_length_o(enc_length_o),
  .status_o    (status_o),
  .last_o      (last_o)
);
